FILE: rtl/rewindable_record_ring_buffer_top_assert.svh
// Assertion macros for the rewindable record ring buffer checker.
// Both use the checker's i_clk and i_rst_n.
`ifndef REWINDABLE_RECORD_RING_BUFFER_TOP_ASSERT_SVH
`define REWINDABLE_RECORD_RING_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RRRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RRRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rrrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrrb_pkg
// Shared constants, beat types and the slot-advance helper of the record ring buffer.
// ----------------------------------------------------------------------------
package rrrb_pkg;

    localparam int DEPTH     = 1024;
    localparam int WORD_BITS = 64;
    localparam int REC_W     = 32;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int FILL_W    = $clog2(DEPTH + 1);
    localparam int ACT_W     = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 3'd0,
        ACT_POP    = 3'd1,
        ACT_MARK   = 3'd2,
        ACT_REWIND = 3'd3,
        ACT_NEWEST = 3'd4
    } t_action;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [WORD_BITS-1:0] entry_data;
    } t_in_beat;

    typedef struct packed {
        logic                 has_entry;
        logic [WORD_BITS-1:0] entry_word;
        logic [REC_W-1:0]     entry_record;
        logic [FILL_W-1:0]    fill_level;
    } t_out_beat;

    // Memory command from pointer control to the store.
    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        t_slot                addr;
        logic [WORD_BITS-1:0] wr_word;
        logic [REC_W-1:0]     wr_record;
    } t_ram_cmd;

    // Result info known at accept time, carried alongside the read.
    typedef struct packed {
        logic              has_entry;
        logic [FILL_W-1:0] fill_level;
    } t_meta;

    function automatic t_slot slot_adv(input t_slot s);
        slot_adv = (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

FILE: rtl/rewindable_record_ring_buffer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rewindable_record_ring_buffer_top
// Status log ring buffer with overwrite of the oldest entry and rewind to mark.
// ----------------------------------------------------------------------------
// Throughput is one action per cycle while the input is not stalled: every
// action does at most one access to the single-port word/record store,
// pointer updates finish in the accept cycle, and read data waits in the
// store read register until the output register takes it, so no two
// accesses to the same slot can overlap. An accepted input beat's result
// passes the store read, then the output register. The input stalls only
// when the read stage holds a result and the output register is full and
// stalled. The store is not cleared after reset; reading a slot that was never
// written is outside the contract, so the block is ready right after reset.
module rewindable_record_ring_buffer_top
    import rrrb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    t_ram_cmd             ram_cmd;
    t_meta                meta;
    logic [WORD_BITS-1:0] rd_word;
    logic [REC_W-1:0]     rd_record;

    logic      r_p1_vld;
    t_meta     r_p1_meta;
    logic      r_out_vld;
    t_out_beat r_out_beat;
    t_out_beat n_out_beat;

    logic out_free;
    logic accept;

    // Output register can load when empty or being taken.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_p1_vld && !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    rrrb_ptr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (i_in_beat),
        .o_cmd    (ram_cmd),
        .o_meta   (meta)
    );

    rrrb_store u_store (
        .i_clk       (i_clk),
        .i_cmd       (ram_cmd),
        .o_rd_word   (rd_word),
        .o_rd_record (rd_record)
    );

    // Read stage: store data arrives here; it holds while this stage waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (accept) begin
            r_p1_vld <= 1'b1;
        end else if (out_free) begin
            r_p1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_meta <= meta;
        end
    end

    // Zero word and record when nothing was read.
    always_comb begin
        n_out_beat.has_entry    = r_p1_meta.has_entry;
        n_out_beat.entry_word   = r_p1_meta.has_entry ? rd_word : '0;
        n_out_beat.entry_record = r_p1_meta.has_entry ? rd_record : '0;
        n_out_beat.fill_level   = r_p1_meta.fill_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_p1_vld) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

endmodule

FILE: rtl/rrrb_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrrb_store
// Word and record memories, one write or one read per cycle, registered read.
// ----------------------------------------------------------------------------
module rrrb_store
    import rrrb_pkg::*;
(
    input  logic                 i_clk,
    input  t_ram_cmd             i_cmd,
    output logic [WORD_BITS-1:0] o_rd_word,
    output logic [REC_W-1:0]     o_rd_record
);

    logic [WORD_BITS-1:0] r_word_mem [DEPTH];
    logic [REC_W-1:0]     r_rec_mem  [DEPTH];
    logic [WORD_BITS-1:0] r_rd_word;
    logic [REC_W-1:0]     r_rd_record;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_word_mem[i_cmd.addr] <= i_cmd.wr_word;
            r_rec_mem[i_cmd.addr]  <= i_cmd.wr_record;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_word   <= r_word_mem[i_cmd.addr];
            r_rd_record <= r_rec_mem[i_cmd.addr];
        end
    end

    assign o_rd_word   = r_rd_word;
    assign o_rd_record = r_rd_record;

endmodule

FILE: rtl/rrrb_ptr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrrb_ptr_ctrl
// Slot pointers, fill count and record counter; issues store accesses.
// ----------------------------------------------------------------------------
module rrrb_ptr_ctrl
    import rrrb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_beat i_beat,
    output t_ram_cmd o_cmd,
    output t_meta    o_meta
);

    t_slot             r_write, n_write;
    t_slot             r_read, n_read;
    t_slot             r_mark, n_mark;
    t_slot             r_newest, n_newest;
    logic [FILL_W-1:0] r_held, n_held;
    logic [REC_W-1:0]  r_rec, n_rec;

    logic [FILL_W-1:0] diff;
    logic [FILL_W:0]   sum;
    logic              wr, rd, hit;
    t_slot             addr;

    always_comb begin
        n_write  = r_write;
        n_read   = r_read;
        n_mark   = r_mark;
        n_newest = r_newest;
        n_held   = r_held;
        n_rec    = r_rec;
        wr       = 1'b0;
        rd       = 1'b0;
        hit      = 1'b0;
        addr     = r_read;
        diff     = FILL_W'(r_read) - FILL_W'(r_mark)
                 + ((r_read < r_mark) ? FILL_W'(DEPTH) : '0);
        sum      = {1'b0, r_held} + {1'b0, diff};
        case (i_beat.action)
            ACT_ADD: begin
                wr       = 1'b1;
                addr     = r_write;
                n_newest = r_write;
                n_write  = slot_adv(r_write);
                n_rec    = r_rec + 1'b1;
                if (r_held >= FILL_W'(DEPTH)) begin
                    // full: overwrite oldest
                    n_read = slot_adv(r_read);
                end else begin
                    n_held = r_held + 1'b1;
                end
            end
            ACT_POP: begin
                if (r_held != '0) begin
                    rd     = 1'b1;
                    hit    = 1'b1;
                    n_held = r_held - 1'b1;
                    n_read = slot_adv(r_read);
                end
            end
            ACT_MARK: begin
                n_mark = r_read;
            end
            ACT_REWIND: begin
                if (sum > (FILL_W + 1)'(DEPTH)) begin
                    n_held = FILL_W'(DEPTH);
                    n_read = slot_adv(r_mark);
                end else begin
                    n_held = sum[FILL_W-1:0];
                    n_read = r_mark;
                end
            end
            ACT_NEWEST: begin
                if (r_held != '0) begin
                    rd   = 1'b1;
                    hit  = 1'b1;
                    addr = r_newest;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write  <= '0;
            r_read   <= '0;
            r_mark   <= '0;
            r_newest <= '0;
            r_held   <= '0;
            r_rec    <= REC_W'(1);
        end else if (i_accept) begin
            r_write  <= n_write;
            r_read   <= n_read;
            r_mark   <= n_mark;
            r_newest <= n_newest;
            r_held   <= n_held;
            r_rec    <= n_rec;
        end
    end

    assign o_cmd.wr_en     = i_accept & wr;
    assign o_cmd.rd_en     = i_accept & rd;
    assign o_cmd.addr      = addr;
    assign o_cmd.wr_word   = i_beat.entry_data;
    assign o_cmd.wr_record = r_rec;

    assign o_meta.has_entry  = hit;
    assign o_meta.fill_level = n_held;

endmodule

FILE: rtl/rrrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrrb_checker
// Port-level checks of the record ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "rewindable_record_ring_buffer_top_assert.svh"

module rrrb_checker
    import rrrb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);

    `RRRB_ASSERT_NOW(a_empty_zero, o_out_valid && !o_out_beat.has_entry, o_out_beat.entry_word == '0 && o_out_beat.entry_record == '0, "result without entry carries nonzero data")

    `RRRB_ASSERT_NOW(a_fill_bound, o_out_valid, o_out_beat.fill_level <= FILL_W'(DEPTH), "fill level above depth")

    `RRRB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_beat), "stalled result beat changed")

endmodule

bind rewindable_record_ring_buffer_top rrrb_checker u_rrrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rewindable_record_ring_buffer_top. Drives log
// actions over the valid/stall input channel. A shadow copy of the ring keeps
// pointers, fill level and stored words and predicts every result beat. The
// result beats are checked field by field in order. Covers the empty cases,
// overwrite when full, rewind across the slot wrap, the rewind clamp, and the
// unused action codes, then a random mix under three idle/stall profiles.
// ----------------------------------------------------------------------------
module tb
    import rrrb_pkg::*;
();

    // Action codes the block must ignore.
    localparam logic [ACT_W-1:0] ACT_RSVD5 = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD7 = 3'd7;

    // Cycle limit for the run guard.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BEATS = 200;   // per idle profile

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // Shadow copy of the ring.
    logic [WORD_BITS-1:0] shadow_word [DEPTH];
    logic [REC_W-1:0]     shadow_rec  [DEPTH];
    bit                   shadow_written [DEPTH];
    t_slot                sh_wr     = '0;
    t_slot                sh_rd     = '0;
    t_slot                sh_mark   = '0;
    t_slot                sh_newest = '0;
    logic [FILL_W-1:0]    sh_held   = '0;
    logic [REC_W-1:0]     sh_next_rec = 1;

    // Expected result beats, oldest first.
    t_out_beat pending_results [$];

    rewindable_record_ring_buffer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run guard: a hang anywhere ends here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rewindable_record_ring_buffer_top verification failed");
            $finish;
        end
    end

    // Receiver back-pressure, changed at the falling edge only.
    always @(negedge clk) begin
        out_stall <= (sink_idle_pct > 0) && ($urandom_range(99) < sink_idle_pct);
    end

    function automatic t_slot step_slot(input t_slot s);
        int nxt;
        nxt = int'(s) + 1;
        if (nxt >= DEPTH)
            nxt = 0;
        return t_slot'(nxt);
    endfunction

    // Applies one accepted action to the shadow ring, returns the expected beat.
    function automatic t_out_beat log_apply(input t_in_beat b);
        t_out_beat r;
        int        gap;
        int        total;
        r = '0;
        case (b.action)
            ACT_ADD: begin
                shadow_word[sh_wr]    = b.entry_data;
                shadow_rec[sh_wr]     = sh_next_rec;
                shadow_written[sh_wr] = 1'b1;
                sh_newest   = sh_wr;
                sh_wr       = step_slot(sh_wr);
                sh_next_rec = sh_next_rec + 1'b1;
                // full: newest overwrites oldest, read pointer follows
                if (int'(sh_held) >= DEPTH)
                    sh_rd = step_slot(sh_rd);
                else
                    sh_held = sh_held + 1'b1;
            end
            ACT_POP: begin
                if (sh_held != 0) begin
                    r.has_entry    = 1'b1;
                    r.entry_word   = shadow_word[sh_rd];
                    r.entry_record = shadow_rec[sh_rd];
                    sh_held = sh_held - 1'b1;
                    sh_rd   = step_slot(sh_rd);
                end
            end
            ACT_MARK: sh_mark = sh_rd;
            ACT_REWIND: begin
                gap = int'(sh_rd) - int'(sh_mark);
                if (gap < 0)
                    gap = gap + DEPTH;
                total = int'(sh_held) + gap;
                if (total > DEPTH) begin
                    sh_held = FILL_W'(DEPTH);
                    sh_rd   = step_slot(sh_mark);
                end else begin
                    sh_held = FILL_W'(total);
                    sh_rd   = sh_mark;
                end
            end
            ACT_NEWEST: begin
                if (sh_held != 0) begin
                    r.has_entry    = 1'b1;
                    r.entry_word   = shadow_word[sh_newest];
                    r.entry_record = shadow_rec[sh_newest];
                end
            end
            default: ;
        endcase
        r.fill_level = sh_held;
        return r;
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Sends one beat; returns at the rising edge that accepted it.
    task automatic post_action(input logic [ACT_W-1:0] act,
                               input logic [WORD_BITS-1:0] data);
        t_in_beat b;
        b.action     = act;
        b.entry_data = data;
        // never read a slot that was not written since reset
        if ((act == ACT_POP && sh_held != 0 && !shadow_written[sh_rd]) ||
            (act == ACT_NEWEST && sh_held != 0 && !shadow_written[sh_newest]))
            b.action = ACT_ADD;
        @(negedge clk);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(log_apply(b));
    endtask

    // Sender holds off until every expected beat is back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk) begin : result_check
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat %h", out_beat);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_beat.has_entry !== want.has_entry) begin
                    $error("has_entry: expected %0h actual %0h",
                           want.has_entry, out_beat.has_entry);
                    mismatch_count++;
                end
                if (out_beat.entry_word !== want.entry_word) begin
                    $error("entry_word: expected %h actual %h",
                           want.entry_word, out_beat.entry_word);
                    mismatch_count++;
                end
                if (out_beat.entry_record !== want.entry_record) begin
                    $error("entry_record: expected %0d actual %0d",
                           want.entry_record, out_beat.entry_record);
                    mismatch_count++;
                end
                if (out_beat.fill_level !== want.fill_level) begin
                    $error("fill_level: expected %0d actual %0d",
                           want.fill_level, out_beat.fill_level);
                    mismatch_count++;
                end
            end
        end
    end

    // Pop, newest, mark and rewind on an empty ring, plus the ignored codes.
    task automatic test_empty_actions();
        post_action(ACT_POP, '1);
        post_action(ACT_NEWEST, '1);
        post_action(ACT_MARK, '0);
        post_action(ACT_REWIND, '0);
        post_action(ACT_RSVD5, '1);
        post_action(ACT_RSVD6, '0);
        post_action(ACT_RSVD7, '1);
    endtask

    // Data extremes, pop order, mark and rewind over a few entries.
    task automatic test_basic_sequence();
        post_action(ACT_ADD, '0);
        post_action(ACT_ADD, '1);
        post_action(ACT_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
        post_action(ACT_ADD, 64'h5555_5555_5555_5555);
        post_action(ACT_NEWEST, '0);
        post_action(ACT_POP, '0);
        post_action(ACT_MARK, '0);
        post_action(ACT_POP, '0);
        post_action(ACT_POP, '0);
        post_action(ACT_NEWEST, '0);
        post_action(ACT_REWIND, '0);
        repeat (4) post_action(ACT_POP, '0);
        post_action(ACT_NEWEST, '0);
        drain_results();
    endtask

    // Read pointer crosses the top slot between mark and rewind, then the ring
    // overflows and a rewind has to clamp at full.
    task automatic test_wrap_and_clamp();
        while (int'(sh_held) < DEPTH - 4)
            post_action(ACT_ADD, rand_word());
        while (sh_held > 2)
            post_action(ACT_POP, '0);
        post_action(ACT_MARK, '0);
        while (sh_rd >= sh_mark) begin
            post_action(ACT_ADD, rand_word());
            post_action(ACT_POP, '0);
        end
        repeat (3) begin
            post_action(ACT_ADD, rand_word());
            post_action(ACT_POP, '0);
        end
        post_action(ACT_REWIND, '0);
        repeat (3) post_action(ACT_POP, '0);
        post_action(ACT_NEWEST, '0);

        while (int'(sh_held) < DEPTH)
            post_action(ACT_ADD, rand_word());
        repeat (20) post_action(ACT_ADD, rand_word());
        post_action(ACT_NEWEST, '0);
        post_action(ACT_MARK, '0);
        repeat (5) post_action(ACT_POP, '0);
        repeat (10) post_action(ACT_ADD, rand_word());
        post_action(ACT_REWIND, '0);
        // rewind on a full ring with nothing skipped
        post_action(ACT_MARK, '0);
        post_action(ACT_REWIND, '0);
        // empty it, checking every surviving entry
        while (sh_held != 0)
            post_action(ACT_POP, '0);
        post_action(ACT_POP, '0);
        drain_results();
    endtask

    // Random mix, weighted toward add and pop so mark/rewind see real traffic.
    task automatic test_random_mix(input int beats);
        int pick;
        repeat (beats) begin
            pick = $urandom_range(99);
            if (pick < 36)
                post_action(ACT_ADD, rand_word());
            else if (pick < 62)
                post_action(ACT_POP, rand_word());
            else if (pick < 72)
                post_action(ACT_NEWEST, rand_word());
            else if (pick < 82)
                post_action(ACT_MARK, rand_word());
            else if (pick < 93)
                post_action(ACT_REWIND, rand_word());
            else begin
                case ($urandom_range(2))
                    0:       post_action(ACT_RSVD5, rand_word());
                    1:       post_action(ACT_RSVD6, rand_word());
                    default: post_action(ACT_RSVD7, rand_word());
                endcase
            end
        end
        drain_results();
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct  = 38;
        sink_idle_pct = 73;
        test_empty_actions();
        test_basic_sequence();

        src_idle_pct  = 73;
        sink_idle_pct = 38;
        test_wrap_and_clamp();

        src_idle_pct  = 38;
        sink_idle_pct = 73;
        test_random_mix(RANDOM_BEATS);
        src_idle_pct  = 73;
        sink_idle_pct = 38;
        test_random_mix(RANDOM_BEATS);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_mix(RANDOM_BEATS);

        // let any stray beat surface before the verdict
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("rewindable_record_ring_buffer_top verification clean");
        end else begin
            $display("rewindable_record_ring_buffer_top verification failed");
        end
        $finish;
    end

endmodule
